>>> src/address_range_source_lookup_top_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the address range source lookup block
// ---------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_SOURCE_LOOKUP_TOP_MACROS_SVH
`define ADDRESS_RANGE_SOURCE_LOOKUP_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ARSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ARSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/arsl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arsl_pkg
// types, codes and the control program of the address range source lookup
// ---------------------------------------------------------------------------
package arsl_pkg;

	localparam int ADDR_W  = 32;
	localparam int LIMIT_W = 33;
	localparam int COUNT_W = 16;
	localparam int SYM_W   = 16;
	localparam int FILE_W  = 16;
	localparam int LINE_W  = 24;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// command codes
	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_FIND = 1'b1
	} cmd_t;

	// sequencer steps
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_INIT,
		S_START,
		S_END,
		S_BISECT,
		S_HIT
	} step_t;

	// table read address source
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_HI,
		RD_MID
	} rd_sel_t;

	// datapath action of a step
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ADD,
		ACT_INIT,
		ACT_CHK_START,
		ACT_CHK_END,
		ACT_BISECT,
		ACT_HIT
	} act_t;

	// jump condition of a step
	typedef enum logic [1:0] {
		JC_DISPATCH,  // wait for a word, find goes to target, add to follow
		JC_ALWAYS,    // go to target
		JC_EXIT,      // miss ends the search, else follow
		JC_BRANCH     // miss ends, lo meets hi goes to target, else follow
	} jump_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		act_t    act;
		jump_t   cond;
		step_t   target;
		step_t   follow;
	} ctrl_t;

	// one table entry
	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [LIMIT_W-1:0] limit;
		logic [SYM_W-1:0]   sym;
		logic [FILE_W-1:0]  fil;
		logic [LINE_W-1:0]  src_line;
	} entry_t;

	// control program
	function automatic ctrl_t ucode_rom(step_t s);
		ctrl_t w;
		w = '{RD_ZERO, ACT_NONE, JC_ALWAYS, S_IDLE, S_IDLE};
		unique case (s)
			S_IDLE:   w = '{RD_ZERO, ACT_NONE,      JC_DISPATCH, S_INIT,  S_ADD};
			S_ADD:    w = '{RD_ZERO, ACT_ADD,       JC_ALWAYS,   S_IDLE,  S_IDLE};
			S_INIT:   w = '{RD_ZERO, ACT_INIT,      JC_EXIT,     S_IDLE,  S_START};
			S_START:  w = '{RD_HI,   ACT_CHK_START, JC_EXIT,     S_IDLE,  S_END};
			S_END:    w = '{RD_MID,  ACT_CHK_END,   JC_BRANCH,   S_HIT,   S_BISECT};
			S_BISECT: w = '{RD_MID,  ACT_BISECT,    JC_BRANCH,   S_HIT,   S_BISECT};
			S_HIT:    w = '{RD_ZERO, ACT_HIT,       JC_ALWAYS,   S_IDLE,  S_IDLE};
			default:  w = '{RD_ZERO, ACT_NONE,      JC_ALWAYS,   S_IDLE,  S_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> src/address_range_source_lookup_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_range_source_lookup_top
// table of code address ranges with symbol, file and line tags, searched by
// binary search under control of a small microcoded sequencer
// ---------------------------------------------------------------------------
// usage
//   a command word is taken at a rising edge with start high and busy low.
//   command add appends [address, address + range_len) with its tags;
//   command find returns the tags of the first entry whose end is above
//   the address, after a check against the first start and the last end.
//   each word gives one result on status/found_* for one cycle with done
//   high; the receiver cannot stall, so the result is simply presented.
//   busy drops in the cycle the result is shown, so a new word is
//   taken only once the word before it has given its result. the pace
//   of a find is set by the single read port of the table: one
//   registered read per search step.
//   reset empties the table (entry count to zero); stored entries are not
//   cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "address_range_source_lookup_top_macros.svh"

module address_range_source_lookup_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [arsl_pkg::ADDR_W-1:0]     address,
	input  logic [arsl_pkg::COUNT_W-1:0]    range_len,
	input  logic [arsl_pkg::SYM_W-1:0]      symbol_id,
	input  logic [arsl_pkg::FILE_W-1:0]     file_id,
	input  logic [arsl_pkg::LINE_W-1:0]     source_line,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [arsl_pkg::SYM_W-1:0]      found_symbol,
	output logic [arsl_pkg::FILE_W-1:0]     found_file,
	output logic [arsl_pkg::LINE_W-1:0]     found_line
);
	import arsl_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// sequencer
	step_t step_q;
	step_t step_n;
	ctrl_t ctrl;
	logic  accept;

	// latched command word
	cmd_t                cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [COUNT_W-1:0]  bcount_q;
	logic [SYM_W-1:0]    sym_q;
	logic [FILE_W-1:0]   fil_q;
	logic [LINE_W-1:0]   line_q;

	// table and search state
	entry_t             table_q [TABLE_DEPTH];
	entry_t             rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;

	// datapath decode
	logic [IDX_W-1:0]   lo_n;
	logic [IDX_W-1:0]   hi_n;
	logic [IDX_W-1:0]   mid_n;
	logic [IDX_W-1:0]   rd_addr;
	logic               miss;
	logic               meet;
	logic               full;
	logic               wr_en;
	entry_t             wr_entry;
	logic               emit;
	status_t            res_status;
	logic [SYM_W-1:0]   res_sym;
	logic [FILE_W-1:0]  res_fil;
	logic [LINE_W-1:0]  res_line;

	// result registers
	logic               done_q;
	status_t            status_q;
	logic [SYM_W-1:0]   sym_out_q;
	logic [FILE_W-1:0]  fil_out_q;
	logic [LINE_W-1:0]  line_out_q;

	assign ctrl   = ucode_rom(step_q);
	assign busy   = (step_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(TABLE_DEPTH));

	// step datapath: search bounds, compares, table write, result
	always_comb begin
		lo_n       = lo_q;
		hi_n       = hi_q;
		miss       = 1'b0;
		wr_en      = 1'b0;
		emit       = 1'b0;
		res_status = ST_OK;
		res_sym    = '0;
		res_fil    = '0;
		res_line   = '0;
		wr_entry.base     = addr_q;
		wr_entry.limit    = {1'b0, addr_q} + LIMIT_W'(bcount_q);
		wr_entry.sym      = sym_q;
		wr_entry.fil      = fil_q;
		wr_entry.src_line = line_q;
		unique case (ctrl.act)
			ACT_NONE: begin
			end
			ACT_ADD: begin
				emit = 1'b1;
				priority if (bcount_q == '0) begin
					res_status = ST_EMPTY;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					wr_en = 1'b1;
				end
			end
			ACT_INIT: begin
				lo_n = '0;
				hi_n = IDX_W'(cnt_q - CNT_W'(1));
				miss = (cnt_q == '0);
			end
			ACT_CHK_START: begin
				miss = (addr_q < rd_q.base);
			end
			ACT_CHK_END: begin
				miss = ({1'b0, addr_q} >= rd_q.limit);
			end
			ACT_BISECT: begin
				if ({1'b0, addr_q} < rd_q.limit) begin
					hi_n = mid_q;
				end else begin
					lo_n = mid_q + IDX_W'(1);
				end
			end
			ACT_HIT: begin
				emit     = 1'b1;
				res_sym  = rd_q.sym;
				res_fil  = rd_q.fil;
				res_line = rd_q.src_line;
			end
			default: begin
			end
		endcase
		if (miss) begin
			emit       = 1'b1;
			res_status = ST_MISS;
		end
		meet  = (lo_n == hi_n);
		mid_n = lo_n + ((hi_n - lo_n) >> 1);
		unique case (ctrl.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_HI:   rd_addr = hi_q;
			RD_MID:  rd_addr = mid_n;
			default: rd_addr = '0;
		endcase
	end

	// next step
	always_comb begin
		step_n = step_q;
		unique case (ctrl.cond)
			JC_DISPATCH: begin
				if (accept) begin
					step_n = (cmd_t'(command) == CMD_FIND) ? ctrl.target : ctrl.follow;
				end
			end
			JC_ALWAYS: step_n = ctrl.target;
			JC_EXIT:   step_n = miss ? S_IDLE : ctrl.follow;
			JC_BRANCH: step_n = miss ? S_IDLE : (meet ? ctrl.target : ctrl.follow);
			default:   step_n = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			step_q <= step_n;
			done_q <= emit;
			if (wr_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// command word latch and search bounds
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(command);
			addr_q   <= address;
			bcount_q <= range_len;
			sym_q    <= symbol_id;
			fil_q    <= file_id;
			line_q   <= source_line;
		end
		lo_q  <= lo_n;
		hi_q  <= hi_n;
		mid_q <= mid_n;
	end

	// range table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[cnt_q[IDX_W-1:0]] <= wr_entry;
		end
		rd_q <= table_q[rd_addr];
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= res_status;
			sym_out_q  <= res_sym;
			fil_out_q  <= res_fil;
			line_out_q <= res_line;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found_symbol = sym_out_q;
	assign found_file   = fil_out_q;
	assign found_line   = line_out_q;

	// checks
	`ARSL_ASSERT_IMPLY(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH),
		"entry count above table depth")
	`ARSL_ASSERT_IMPLY(a_done_after_busy, clk, arst_n, done_q, $past(step_q) != S_IDLE,
		"result without a word in progress")
	`ARSL_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy,
		"accepted word did not start the sequencer")
	`ARSL_ASSERT_IMPLY(a_bounds_order, clk, arst_n, step_q == S_BISECT, lo_q < hi_q,
		"search bounds crossed in bisection")
	`ARSL_ASSERT_IMPLY(a_add_find_only, clk, arst_n,
		(step_q == S_ADD) && ($past(step_q) == S_IDLE), cmd_q == CMD_ADD,
		"find word routed to the add step")

endmodule
